### sv/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine: opcodes, status codes
// and the command word broadcast to every storage cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 7;

    // Operation codes carried in the input word
    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_READ     = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_CLEAR    = 3'd5
    } opcode_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Action that a cell takes on its stored entry
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_CLEAR
    } cell_op_t;

    // Command broadcast to the row of cells
    typedef struct packed {
        cell_op_t               kind;
        logic [POS_W-1:0]       pos;
        logic [VAL_W-1:0]       value;
        logic                   load;     // a word is accepted this cycle
        logic                   rd_en;    // valid read at pos
        logic                   srch_en;  // membership search for value
    } olist_cmd_t;

endpackage

`default_nettype wire

### sv/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// One slot of the list. Holds a single entry, shifts it to or from its
// neighbors on insert and delete, and flags a read or search hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olist_cell
    import olist_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire olist_cmd_t         cmd,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [VAL_W-1:0]   left_data,   // entry of the cell below
    input  wire logic [VAL_W-1:0]   right_data,  // entry of the cell above
    output logic      [VAL_W-1:0]   entry,
    output logic      [VAL_W-1:0]   rd_data,
    output logic                    hit
);

    logic [VAL_W-1:0] entry_reg, entry_next;
    logic [VAL_W-1:0] rd_reg, rd_next;
    logic             hit_reg, hit_next;
    logic             at_pos, above_pos, at_count, below_count;

    // position relations of this slot
    assign at_pos      = (IDX == int'(cmd.pos));
    assign above_pos   = (IDX >  int'(cmd.pos));
    assign at_count    = (IDX == int'(count));
    assign below_count = (IDX <  int'(count));

    // next entry
    always_comb begin
        entry_next = entry_reg;
        case (cmd.kind)
            CELL_APPEND: begin
                if (at_count) entry_next = cmd.value;
            end
            CELL_INSERT: begin
                if (above_pos)   entry_next = left_data;
                else if (at_pos) entry_next = cmd.value;
            end
            CELL_DELETE: begin
                if (above_pos || at_pos) entry_next = right_data;
            end
            CELL_CLEAR:  entry_next = '0;
            default:     entry_next = entry_reg;
        endcase
    end

    // read and search taps, sampled against the state before the update
    assign rd_next  = (cmd.rd_en && at_pos) ? entry_reg : '0;
    assign hit_next = cmd.srch_en && below_count && (entry_reg == cmd.value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_reg  <= rd_next;
            hit_reg <= hit_next;
        end
    end

    assign entry   = entry_reg;
    assign rd_data = rd_reg;
    assign hit     = hit_reg;

endmodule

`default_nettype wire

### sv/ordered_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine
// Fixed-capacity ordered list of 32-bit handles held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command word: opcode, position and handle. Each
//   accepted word returns exactly one result word on the m_ channel with
//   status, read value, found flag and the entry count after the command.
//   Insert shifts the cells above the position, and delete the cells at or
//   above it, one place at once, so any command finishes in one row update.
//   A result passes the cell row and middle stage, then the read/search OR
//   reduction into the output register, before m_tvalid rises.
//   Throughput: 1 word per cycle while m_tready is not held low; one command
//   per cycle is set by the cell row updating all entries at once.
//   Reset (aresetn low, synchronous) clears every entry and the count, and
//   drops all words in flight. When the receiver holds m_tready low, the
//   output register and the middle stage fill and s_tready falls; nothing is
//   lost and the list does not change until s_ words are taken again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete_engine
    import olist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // opcode[2:0], position[9:3], element_value[41:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // status[1:0], read_value[33:2], found[34],
                                        // entry_count[41:35]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // input word fields
    opcode_t           in_op;
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;

    assign in_op  = opcode_t'(s_tdata[2:0]);
    assign in_pos = s_tdata[9:3];
    assign in_val = s_tdata[41:10];

    logic accept, advance;
    logic [CW-1:0] count_reg, count_next;
    logic p1_valid_reg;
    status_t p1_status_reg, status_next;
    logic [ECNT_W-1:0] p1_count_reg;
    logic m_tvalid_reg;
    status_t m_status_reg;
    logic [VAL_W-1:0] m_read_reg;
    logic m_found_reg;
    logic [ECNT_W-1:0] m_count_reg;

    olist_cmd_t cmd;
    logic [CMPW-1:0] pos_c, cnt_c, cnt_next_c;
    logic full;

    // handshake: middle stage moves when the output register is free
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance || !p1_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign pos_c = CMPW'(in_pos);
    assign cnt_c = CMPW'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));

    // command decode and bounds checks
    always_comb begin
        cmd         = '0;
        cmd.kind    = CELL_HOLD;
        cmd.pos     = in_pos;
        cmd.value   = in_val;
        cmd.load    = accept;
        status_next = ST_OK;
        count_next  = count_reg;
        unique case (in_op)
            OP_APPEND: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.kind   = CELL_APPEND;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.kind   = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE: begin
                if (pos_c >= cnt_c) begin
                    status_next = ST_RANGE;
                end else begin
                    cmd.kind   = CELL_DELETE;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ: begin
                if (pos_c >= cnt_c) status_next = ST_RANGE;
                else                cmd.rd_en   = 1'b1;
            end
            OP_CONTAINS: cmd.srch_en = 1'b1;
            OP_CLEAR: begin
                cmd.kind   = CELL_CLEAR;
                count_next = '0;
            end
            default: ;
        endcase
        // nothing moves without an accepted word
        if (!accept) begin
            cmd.kind    = CELL_HOLD;
            cmd.rd_en   = 1'b0;
            cmd.srch_en = 1'b0;
            count_next  = count_reg;
        end
    end

    assign cnt_next_c = CMPW'(count_next);

    // row of cells
    logic [VAL_W-1:0] entry_w [CAPACITY];
    logic [VAL_W-1:0] left_w  [CAPACITY];
    logic [VAL_W-1:0] right_w [CAPACITY];
    logic [VAL_W-1:0] rd_w    [CAPACITY];
    logic [CAPACITY-1:0] hit_w;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_w[g] = '0;
        end else begin : g_mid
            assign left_w[g] = entry_w[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w[g] = '0;
        end else begin : g_inner
            assign right_w[g] = entry_w[g+1];
        end

        olist_cell #(
            .IDX   (g),
            .CNT_W (CW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .count      (count_reg),
            .left_data  (left_w[g]),
            .right_data (right_w[g]),
            .entry      (entry_w[g]),
            .rd_data    (rd_w[g]),
            .hit        (hit_w[g])
        );
    end

    // OR reduction of the read taps
    logic [VAL_W-1:0] rd_any;
    always_comb begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_any = rd_any | rd_w[i];
        end
    end

    // count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // middle stage: status and count beside the cell taps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg <= status_next;
            p1_count_reg  <= cnt_next_c[ECNT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            m_status_reg <= p1_status_reg;
            m_read_reg   <= rd_any;
            m_found_reg  <= |hit_w;
            m_count_reg  <= p1_count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_found_reg, m_read_reg, m_status_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_op == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the list");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_op == OP_APPEND) && !full
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not add one entry");

    a_no_change_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> (count_reg == $past(count_reg)))
        else $error("count changed without an accepted word");

endmodule

`default_nettype wire
